/* design/tmix_pkg.sv */
// ----------------------------------------------------------------------------
// tmix_pkg
// shared widths, controller states, command/status structs and pitch table
// ----------------------------------------------------------------------------
package tmix_pkg;

  localparam int SAMPLE_RATE_DEF = 44100;

  localparam int NOTE_W   = 7;
  localparam int AMP_W    = 15;
  localparam int SMP_W    = 16;
  localparam int PHASE_W  = 10;
  localparam int BASE_W   = 9;
  localparam int OCT_W    = 4;
  localparam int SEMI_W   = 4;
  localparam int F_W      = 17;   // 494 << 8 fits
  localparam int PROD_W   = AMP_W + F_W;
  localparam int DIV_W    = PROD_W + 1;

  localparam int IN_TDATA_W  = 40; // note_number, amplitude, mix_in, padded
  localparam int OUT_TDATA_W = 16;

  localparam logic [PHASE_W-1:0] PERIOD_MAX = 10'd1023;
  localparam logic [AMP_W-1:0]   SLOPE_MAX  = 15'd32767;

  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001,
    S_FREQ = 8'b00000010,
    S_MUL  = 8'b00000100,
    S_RCPL = 8'b00001000,
    S_RCPH = 8'b00010000,
    S_DIVP = 8'b00100000,
    S_TONE = 8'b01000000,
    S_OUT  = 8'b10000000
  } state_t;

  typedef struct packed {
    logic cap;        // capture input item
    logic ld_freq;    // register note frequency
    logic ld_prod;    // register amplitude times frequency
    logic div_period; // start period division
    logic rcp_lo;     // slope reciprocal, low half product
    logic rcp_hi;     // slope reciprocal, high half product accumulated
    logic ld_note;    // latch slope, period and peak, clear phase
    logic ld_tone;    // register triangle product
    logic out_load;   // write output register, advance phase
  } cmd_t;

  typedef struct packed {
    logic note_start;
    logic div_busy;
  } sts_t;

  function automatic logic [BASE_W-1:0] semitone_hz(input logic [SEMI_W-1:0] idx);
    logic [BASE_W-1:0] hz;
    case (idx)
      4'd0:    hz = 9'd261;
      4'd1:    hz = 9'd277;
      4'd2:    hz = 9'd293;
      4'd3:    hz = 9'd311;
      4'd4:    hz = 9'd329;
      4'd5:    hz = 9'd349;
      4'd6:    hz = 9'd370;
      4'd7:    hz = 9'd392;
      4'd8:    hz = 9'd415;
      4'd9:    hz = 9'd440;
      4'd10:   hz = 9'd466;
      4'd11:   hz = 9'd494;
      default: hz = 9'd0;
    endcase
    return hz;
  endfunction

endpackage

/* design/tmix_div.sv */
// ----------------------------------------------------------------------------
// tmix_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module tmix_div #(
  parameter int DIV_W = tmix_pkg::DIV_W,
  parameter int DVS_W = tmix_pkg::F_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             busy,
  output logic [DIV_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] quo_r, quo_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W-1:0] dvs_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;

  assign trial = {rem_r, quo_r[DIV_W-1]};
  assign diff  = trial - {1'b0, dvs_r};

  always_comb begin
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    if (start) begin
      quo_nxt = dividend;
      rem_nxt = '0;
      cnt_nxt = CNT_W'(DIV_W);
    end else if (cnt_r != '0) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = diff[DVS_W-1:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DVS_W-1:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign busy     = (cnt_r != '0);
  assign quotient = quo_r;

endmodule

/* design/tmix_dpath.sv */
// ----------------------------------------------------------------------------
// tmix_dpath
// note pitch math, tone state, triangle sample and mix adder
// ----------------------------------------------------------------------------
module tmix_dpath #(
  parameter int SAMPLE_RATE = tmix_pkg::SAMPLE_RATE_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  tmix_pkg::cmd_t                    cmd,
  input  logic                              in_start,
  input  logic [tmix_pkg::IN_TDATA_W-1:0]   in_data,
  output tmix_pkg::sts_t                    sts,
  output logic [tmix_pkg::OUT_TDATA_W-1:0]  out_data
);

  localparam int SR_W  = $clog2(SAMPLE_RATE + 1);
  localparam int DVS_W = (SR_W > tmix_pkg::F_W) ? SR_W : tmix_pkg::F_W;
  localparam int NW    = tmix_pkg::NOTE_W;
  localparam int AW    = tmix_pkg::AMP_W;
  localparam int SW    = tmix_pkg::SMP_W;
  localparam int PW    = tmix_pkg::PHASE_W;
  localparam int FW    = tmix_pkg::F_W;
  localparam int PDW   = tmix_pkg::PROD_W;
  localparam int HW    = PDW / 2;
  localparam int MW    = PW + AW;

  // slope = 2*prod / SAMPLE_RATE by reciprocal multiply, exact while
  // prod < 16384*SAMPLE_RATE; anything above saturates
  localparam int RCP_SH = 14 + 2 * SR_W;
  localparam int RCP_W  = 17 + SR_W;
  localparam int ACC_W  = PDW + RCP_W;
  localparam longint unsigned RCP_M =
    ((64'd1 << (RCP_SH + 1)) + 64'(SAMPLE_RATE) - 64'd1) / 64'(SAMPLE_RATE);
  localparam logic [RCP_W-1:0] RCP_K   = RCP_W'(RCP_M);
  localparam logic [PDW-1:0]   SAT_LIM = PDW'(64'd16384 * 64'(SAMPLE_RATE));

  // captured item
  logic          start_r;
  logic [NW-1:0] note_r;
  logic [AW-1:0] amp_r;
  logic [SW-1:0] mix_r;

  // tone state
  logic [PW-1:0] phase_r, phase_nxt;
  logic [PW-1:0] period_r;
  logic [AW-1:0] slope_r;
  logic [AW-1:0] peak_r;

  logic [FW-1:0] f_r, f_nxt;
  logic [SW-1:0] wprod_r;
  logic [SW-1:0] out_r;

  // octave = note / 12 via reciprocal, exact for 7-bit notes
  logic [NW+7:0]                  oct_mul;
  logic [tmix_pkg::OCT_W-1:0]     octave;
  logic [NW-1:0]                  oct_base;
  logic [NW-1:0]                  semi_full;
  logic [FW-1:0]                  base_hz;

  assign oct_mul   = (NW+8)'(note_r) * (NW+8)'(171);
  assign octave    = oct_mul[NW+7:11];
  assign oct_base  = NW'(octave) * NW'(12);
  assign semi_full = note_r - oct_base;
  assign base_hz   = FW'(tmix_pkg::semitone_hz(semi_full[tmix_pkg::SEMI_W-1:0]));

  always_comb begin
    if (octave >= 4'd2) begin
      f_nxt = base_hz << (octave - 4'd2);
    end else begin
      f_nxt = base_hz >> (4'd2 - octave);
    end
  end

  // amplitude * f, then times the scaled reciprocal in two half-width steps
  logic [PDW-1:0]      prod_r;
  logic [ACC_W-1:0]    acc_r;
  logic [HW-1:0]       rcp_sel;
  logic [RCP_W+HW-1:0] rcp_part;

  assign rcp_sel  = cmd.rcp_hi ? prod_r[PDW-1:HW] : prod_r[HW-1:0];
  assign rcp_part = (RCP_W+HW)'(rcp_sel) * (RCP_W+HW)'(RCP_K);

  // period = SAMPLE_RATE / f on the serial divider
  logic [SR_W-1:0]  div_dividend;
  logic [DVS_W-1:0] div_divisor;
  logic [SR_W-1:0]  quotient;
  logic             div_busy;

  assign div_dividend = SR_W'(SAMPLE_RATE);
  assign div_divisor  = DVS_W'(f_r);

  tmix_div #(
    .DIV_W (SR_W),
    .DVS_W (DVS_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_period),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (quotient)
  );

  logic [AW-1:0] slope_sat;
  logic [PW-1:0] period_sat;

  assign slope_sat = (prod_r >= SAT_LIM) ? tmix_pkg::SLOPE_MAX : acc_r[RCP_SH +: AW];
  always_comb begin
    if (quotient == '0) begin
      period_sat = PW'(1);
    end else if (quotient > SR_W'(tmix_pkg::PERIOD_MAX)) begin
      period_sat = tmix_pkg::PERIOD_MAX;
    end else begin
      period_sat = quotient[PW-1:0];
    end
  end

  // triangle sample
  logic [MW-1:0] wprod_full;
  logic          rising;
  logic [SW-1:0] wave;
  logic [PW:0]   phase_inc;

  assign wprod_full = MW'(phase_r) * MW'(slope_r);
  assign rising     = phase_r < (period_r >> 1);
  assign wave       = rising ? wprod_r : (SW'({peak_r, 1'b0}) - wprod_r);
  assign phase_inc  = {1'b0, phase_r} + (PW+1)'(1);
  assign phase_nxt  = (phase_inc >= {1'b0, period_r}) ? '0 : phase_inc[PW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= '0;
      period_r <= PW'(1);
      slope_r  <= '0;
      peak_r   <= '0;
    end else begin
      if (cmd.ld_note) begin
        slope_r  <= slope_sat;
        period_r <= period_sat;
        peak_r   <= amp_r;
        phase_r  <= '0;
      end else if (cmd.out_load) begin
        phase_r <= phase_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      start_r <= in_start;
      note_r  <= in_data[NW-1:0];
      amp_r   <= in_data[NW+AW-1:NW];
      mix_r   <= in_data[NW+AW+SW-1:NW+AW];
    end
    if (cmd.ld_freq) begin
      f_r <= f_nxt;
    end
    if (cmd.ld_prod) begin
      prod_r <= PDW'(amp_r) * PDW'(f_r);
    end
    if (cmd.rcp_lo) begin
      acc_r <= ACC_W'(rcp_part);
    end else if (cmd.rcp_hi) begin
      acc_r <= acc_r + (ACC_W'(rcp_part) << HW);
    end
    if (cmd.ld_tone) begin
      wprod_r <= wprod_full[SW-1:0];
    end
    if (cmd.out_load) begin
      out_r <= mix_r + wave;
    end
  end

  assign sts.note_start = start_r;
  assign sts.div_busy   = div_busy;
  assign out_data       = out_r;

endmodule

/* design/tmix_ctrl.sv */
// ----------------------------------------------------------------------------
// tmix_ctrl
// sequencer for one item: capture, optional note latch, tone, output
// ----------------------------------------------------------------------------
module tmix_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic                out_tready,
  input  tmix_pkg::sts_t      sts,
  output logic                in_tready,
  output logic                out_tvalid,
  output tmix_pkg::cmd_t      cmd,
  output tmix_pkg::state_t    state
);

  tmix_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             slot_free;

  assign slot_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      tmix_pkg::S_IDLE: begin
        if (in_tvalid) begin
          cmd.cap   = 1'b1;
          state_nxt = tmix_pkg::S_FREQ;
        end
      end
      tmix_pkg::S_FREQ: begin
        if (sts.note_start) begin
          cmd.ld_freq = 1'b1;
          state_nxt   = tmix_pkg::S_MUL;
        end else begin
          cmd.ld_tone = 1'b1;
          state_nxt   = tmix_pkg::S_OUT;
        end
      end
      tmix_pkg::S_MUL: begin
        cmd.ld_prod    = 1'b1;
        cmd.div_period = 1'b1;
        state_nxt      = tmix_pkg::S_RCPL;
      end
      tmix_pkg::S_RCPL: begin
        cmd.rcp_lo = 1'b1;
        state_nxt  = tmix_pkg::S_RCPH;
      end
      tmix_pkg::S_RCPH: begin
        cmd.rcp_hi = 1'b1;
        state_nxt  = tmix_pkg::S_DIVP;
      end
      tmix_pkg::S_DIVP: begin
        if (!sts.div_busy) begin
          cmd.ld_note = 1'b1;
          state_nxt   = tmix_pkg::S_TONE;
        end
      end
      tmix_pkg::S_TONE: begin
        cmd.ld_tone = 1'b1;
        state_nxt   = tmix_pkg::S_OUT;
      end
      tmix_pkg::S_OUT: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = tmix_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = tmix_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tmix_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == tmix_pkg::S_IDLE);
  assign out_tvalid = out_valid_r;
  assign state      = state_r;

endmodule

/* design/triangle_tone_mixer.sv */
// ----------------------------------------------------------------------------
// triangle_tone_mixer
// adds a triangle tone, pitched from a semitone table, to a sample stream
// ----------------------------------------------------------------------------
//
// channel   dir   tdata                                          tuser
// in_       in    [6:0] note_number, [21:7] amplitude,           note_start
//                 [37:22] mix_in (signed), [39:38] zero
// out_      out   [15:0] mix_out (signed)                        -
//
// sequence: an item without note start goes from accept to the tone product
//   and then to the output register load; a note start first runs a 16-step
//   serial division for the period at 44.1 kHz while the slope comes from a
//   two-step reciprocal multiply
// reset: rst_n synchronous active low; period 1, phase, slope, peak zero
// stalls: one item in flight; the output register holds a result while the
//   next item is accepted and worked on, the load waits for the slot
//
module triangle_tone_mixer #(
  parameter int SAMPLE_RATE = tmix_pkg::SAMPLE_RATE_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input items
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [tmix_pkg::IN_TDATA_W-1:0]   in_tdata,  // note_number, amplitude, mix_in
  input  logic                              in_tuser,  // note_start
  // result items
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [tmix_pkg::OUT_TDATA_W-1:0]  out_tdata  // mix_out
);

  // command and status between controller and datapath
  tmix_pkg::cmd_t   cmd;
  tmix_pkg::sts_t   sts;
  tmix_pkg::state_t state;

  // sequencer: walks each item through capture, pitch latch on a note start, tone, output
  tmix_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .cmd        (cmd),
    .state      (state)
  );

  // datapath: frequency, period divider, slope reciprocal, tone state, mix adder
  tmix_dpath #(
    .SAMPLE_RATE (SAMPLE_RATE)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_start (in_tuser),
    .in_data  (in_tdata),
    .sts      (sts),
    .out_data (out_tdata)
  );

  // one item at a time: accept closes the input until the item is done
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while an item is in flight");

  // divider must be quiet whenever the sequencer is idle
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state == tmix_pkg::S_IDLE) |-> !sts.div_busy)
    else $error("divider busy in idle");

  // a fresh result only comes out of the output state
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state == tmix_pkg::S_OUT))
    else $error("output valid without output state");

endmodule
